// File: rtl/positional_list_store_macros.svh
// ---------------------------------------------------------------------------
// positional_list_store_macros.svh
// assertion macros for the positional list store
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define PLS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional_list_store: same-cycle check failed");
// next-cycle implication, sampled on clk, off during reset
`define PLS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional_list_store: next-cycle check failed");
`else
`define PLS_ASSERT_IMP(label, ante, cons)
`define PLS_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: rtl/pls_pkg.sv
// ---------------------------------------------------------------------------
// pls_pkg
// shared types and codes of the positional list store
// ---------------------------------------------------------------------------
package pls_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND     = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE     = 2'd2;

  typedef enum logic [2:0] {
    ACT_IDLE,
    ACT_PUSH_FRONT,
    ACT_APPEND,
    ACT_DELETE,
    ACT_ROTATE
  } act_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    act_t                     act;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
  } cell_ctrl_t;

endpackage

// File: rtl/pls_if.sv
// ---------------------------------------------------------------------------
// pls_in_if / pls_out_if
// valid/ready channels for commands and list readout items
// ---------------------------------------------------------------------------
interface pls_in_if;
  logic                             valid;
  logic                             ready;
  logic [pls_pkg::OP_W-1:0]         op;
  logic signed [pls_pkg::DATA_W-1:0] value;
  logic [pls_pkg::POS_W-1:0]        position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface pls_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [pls_pkg::DATA_W-1:0] element;
  logic                             is_last;
  logic                             list_empty;
  logic                             dropped_full;

  modport source (output valid, output element, output is_last, output list_empty,
                  output dropped_full, input ready);
  modport sink   (input valid, input element, input is_last, input list_empty,
                  input dropped_full, output ready);
endinterface

// File: rtl/pls_cell.sv
// ---------------------------------------------------------------------------
// pls_cell
// one list slot; picks its next value from itself, a neighbor, the head slot or the command
// ---------------------------------------------------------------------------
module pls_cell #(
  parameter int IDX = 0,
  parameter int LW  = 5
) (
  input  logic                              clk,
  input  pls_pkg::cell_ctrl_t               ctrl,
  input  logic [LW-1:0]                     len,
  input  logic signed [pls_pkg::DATA_W-1:0] left_data,
  input  logic signed [pls_pkg::DATA_W-1:0] right_data,
  input  logic signed [pls_pkg::DATA_W-1:0] head_data,
  output logic signed [pls_pkg::DATA_W-1:0] data_r
);

  localparam logic [LW-1:0]              IDX_L = LW'(IDX);
  localparam logic [pls_pkg::POS_W-1:0]  IDX_P = pls_pkg::POS_W'(IDX);

  logic signed [pls_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.act)
      pls_pkg::ACT_PUSH_FRONT: begin
        data_nxt = (IDX == 0) ? ctrl.value : left_data;
      end
      pls_pkg::ACT_APPEND: begin
        if (IDX_L == len) data_nxt = ctrl.value;
      end
      pls_pkg::ACT_DELETE: begin
        if (IDX_P >= ctrl.pos) data_nxt = right_data;
      end
      pls_pkg::ACT_ROTATE: begin
        // rotate left within the occupied slots, head wraps to the tail
        if (IDX_L == len - LW'(1)) data_nxt = head_data;
        else if (IDX_L < len)      data_nxt = right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// File: rtl/positional_list_store.sv
// ---------------------------------------------------------------------------
// positional_list_store
// bounded ordered list with front insert, back append and positional delete
// ---------------------------------------------------------------------------
// The list lives in a row of DEPTH cells, slot 0 at the front. When a
// command is taken, the cells update at once from a neighbor (shift right
// for a front insert, shift left from the delete position) or from the
// command value (append). The block then reads the list out, one item per
// cycle from slot 0 while the sink is ready, rotating the occupied cells
// left on every handshake so that after the last item the list is back in
// order. A new command is taken only once the whole readout has gone out.
// An empty list reads out as one item with list_empty set and element zero;
// an insert into a full list is dropped and dropped_full is set on every
// item of that readout. Entries carry no reset: only occupied slots are
// ever shown.
// ---------------------------------------------------------------------------
`include "positional_list_store_macros.svh"

module positional_list_store #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  pls_in_if.sink            in_ch,
  pls_out_if.source         out_ch
);

  localparam int LW = $clog2(DEPTH + 1);  // length, holds DEPTH itself
  localparam int CW = $clog2(DEPTH);      // readout counter, below DEPTH

  // control state
  pls_pkg::state_t state_r, state_nxt;
  logic [LW-1:0]   length_r, length_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            dropped_r, dropped_nxt;

  // chain
  pls_pkg::cell_ctrl_t               ctrl;
  logic signed [pls_pkg::DATA_W-1:0] cell_q [DEPTH];

  logic in_fire, out_fire, full, pos_ok, last_item, empty;

  assign full      = (length_r == LW'(DEPTH));
  assign pos_ok    = (in_ch.position < pls_pkg::POS_W'(length_r));
  assign empty     = (length_r == '0);
  assign last_item = empty || (LW'(cnt_r) == length_r - LW'(1));
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_ch.valid && out_ch.ready;

  // command decode and readout rotation, broadcast to all cells
  always_comb begin
    ctrl.act   = pls_pkg::ACT_IDLE;
    ctrl.value = in_ch.value;
    ctrl.pos   = in_ch.position;
    if (in_fire) begin
      case (in_ch.op)
        pls_pkg::OP_PUSH_FRONT: if (!full) ctrl.act = pls_pkg::ACT_PUSH_FRONT;
        pls_pkg::OP_APPEND:     if (!full) ctrl.act = pls_pkg::ACT_APPEND;
        pls_pkg::OP_DELETE:     if (pos_ok) ctrl.act = pls_pkg::ACT_DELETE;
        default:                ctrl.act = pls_pkg::ACT_IDLE;
      endcase
    end else if (out_fire && !empty) begin
      ctrl.act = pls_pkg::ACT_ROTATE;
    end
  end

  // the row of cells; the ends get the command value and their own data
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [pls_pkg::DATA_W-1:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = ctrl.value;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = cell_q[g];
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end
    pls_cell #(.IDX(g), .LW(LW)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .len        (length_r),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_q[0]),
      .data_r     (cell_q[g])
    );
  end

  // next state
  always_comb begin
    state_nxt   = state_r;
    length_nxt  = length_r;
    cnt_nxt     = cnt_r;
    dropped_nxt = dropped_r;
    case (state_r)
      pls_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt   = pls_pkg::ST_EMIT;
          cnt_nxt     = '0;
          dropped_nxt = 1'b0;
          case (ctrl.act)
            pls_pkg::ACT_PUSH_FRONT,
            pls_pkg::ACT_APPEND: length_nxt = length_r + LW'(1);
            pls_pkg::ACT_DELETE: length_nxt = length_r - LW'(1);
            default:             length_nxt = length_r;
          endcase
          // insert into a full list
          if (full && (in_ch.op == pls_pkg::OP_PUSH_FRONT ||
                       in_ch.op == pls_pkg::OP_APPEND)) begin
            dropped_nxt = 1'b1;
          end
        end
      end
      pls_pkg::ST_EMIT: begin
        if (out_fire) begin
          if (last_item) state_nxt = pls_pkg::ST_IDLE;
          else           cnt_nxt   = cnt_r + CW'(1);
        end
      end
      default: state_nxt = pls_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready         = 1'b0;
    out_ch.valid        = 1'b0;
    out_ch.element      = empty ? '0 : cell_q[0];
    out_ch.is_last      = last_item;
    out_ch.list_empty   = empty;
    out_ch.dropped_full = dropped_r;
    case (state_r)
      pls_pkg::ST_IDLE: in_ch.ready  = 1'b1;
      pls_pkg::ST_EMIT: out_ch.valid = 1'b1;
      default: begin
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pls_pkg::ST_IDLE;
      length_r  <= '0;
      cnt_r     <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      length_r  <= length_nxt;
      cnt_r     <= cnt_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // checks
  `PLS_ASSERT_IMP(a_len_bound, 1'b1, length_r <= LW'(DEPTH))
  `PLS_ASSERT_IMP(a_one_side, in_ch.ready, !out_ch.valid)
  `PLS_ASSERT_NXT(a_full_drop, in_fire && full && in_ch.op != pls_pkg::OP_DELETE, $stable(length_r))
  `PLS_ASSERT_NXT(a_last_idle, out_fire && last_item, state_r == pls_pkg::ST_IDLE)

endmodule
